@@ hdl/sound_register_write_command_encoder_assert.svh @@
// Assertion macros for the sound register write command encoder checker.
// Depends on nothing; included by the checker file.
`ifndef SOUND_REGISTER_WRITE_COMMAND_ENCODER_ASSERT_SVH
`define SOUND_REGISTER_WRITE_COMMAND_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SRWCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srwce check failed");

// Next-cycle implication, disabled while reset is low.
`define SRWCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srwce check failed");

`endif

@@ hdl/srwce_pkg.sv @@
// Shared types and constants of the sound register write command encoder.
// No dependencies; used by the front end, queue, back end and top level.
`timescale 1ns / 1ps
`default_nettype none
package srwce_pkg;

    localparam int BATCH_LIMIT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] PCM_MASK = 32'hFFFF00FF;
    localparam logic [31:0] PCM_PLAY = 32'hFFFF0000;
    localparam logic [31:0] PCM_STOP = 32'hFFFF0002;
    localparam logic [7:0]  PCM_CMD  = 8'h50 | 8'h0C;
    localparam logic [7:0]  HDR_PSG   = 8'h10;
    localparam logic [7:0]  HDR_PORT0 = 8'h20;
    localparam logic [7:0]  HDR_PORT1 = 8'h30;
    localparam logic [5:0]  NO_SAMPLE = 6'd63;
    localparam logic [31:0] PORT1_MASK = 32'h00000300;
    localparam logic [31:0] PORT1_SEL  = 32'h00000100;
    localparam logic [31:0] PORT0_END  = 32'h00000100;

    localparam logic       FUNC_FLUSH = 1'b1;
    localparam logic [1:0] CHIP_FM  = 2'd0;
    localparam logic [1:0] CHIP_PSG = 2'd1;
    localparam logic [1:0] CHIP_DAC = 2'd2;

    typedef enum logic [1:0] {
        OP_PCM       = 2'd0,
        OP_PUSH      = 2'd1,
        OP_FLUSH_FM  = 2'd2,
        OP_FLUSH_PSG = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SEL_P0  = 2'd0,
        SEL_P1  = 2'd1,
        SEL_PSG = 2'd2
    } t_sel;

    typedef struct packed {
        t_op        op;
        t_sel       sel;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

    function automatic logic [7:0] hdr_base(input t_sel sel);
        logic [7:0] base;
        case (sel)
            SEL_P0:  base = HDR_PORT0;
            SEL_P1:  base = HDR_PORT1;
            SEL_PSG: base = HDR_PSG;
            default: base = HDR_PSG;
        endcase
        return base;
    endfunction

endpackage
`default_nettype wire

@@ hdl/srwce_front.sv @@
// Front end: classifies each input transaction into a back-end command or drops it.
// Depends on srwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srwce_front (
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_func,
    input  wire logic [1:0]       i_chip,
    input  wire logic [31:0]      i_addr,
    input  wire logic [7:0]       i_value,
    input  wire logic [5:0]       i_slot,
    input  wire logic [1:0]       i_base,
    input  wire logic             i_q_ready,
    output logic                  o_push,
    output srwce_pkg::t_cmd       o_cmd
);

    logic       is_play;
    logic       is_stop;
    logic [1:0] chan;
    logic       keep;
    logic       pcm_keep;
    logic [7:0] pcm_data;

    assign is_play  = (i_addr & srwce_pkg::PCM_MASK) == srwce_pkg::PCM_PLAY;
    assign is_stop  = (i_addr & srwce_pkg::PCM_MASK) == srwce_pkg::PCM_STOP;
    assign chan     = i_base + i_addr[9:8];
    assign pcm_keep = is_stop || (is_play && (i_slot != srwce_pkg::NO_SAMPLE));
    assign pcm_data = is_play ? (8'(i_slot) + 8'd1) : 8'h00;

    always_comb begin
        keep     = 1'b0;
        o_cmd.op  = srwce_pkg::OP_PCM;
        o_cmd.sel = srwce_pkg::SEL_P0;
        o_cmd.b0  = srwce_pkg::PCM_CMD | {6'd0, chan};
        o_cmd.b1  = pcm_data;
        if (i_func == srwce_pkg::FUNC_FLUSH) begin
            if (i_chip == srwce_pkg::CHIP_FM) begin
                keep     = 1'b1;
                o_cmd.op = srwce_pkg::OP_FLUSH_FM;
            end else if (i_chip == srwce_pkg::CHIP_PSG) begin
                keep      = 1'b1;
                o_cmd.op  = srwce_pkg::OP_FLUSH_PSG;
                o_cmd.sel = srwce_pkg::SEL_PSG;
            end
        end else if (i_chip == srwce_pkg::CHIP_FM) begin
            if (is_play || is_stop) begin
                keep = pcm_keep;
            end else if (i_addr < srwce_pkg::PORT0_END) begin
                keep     = 1'b1;
                o_cmd.op = srwce_pkg::OP_PUSH;
                o_cmd.b0 = i_addr[7:0];
                o_cmd.b1 = i_value;
            end else if ((i_addr & srwce_pkg::PORT1_MASK) == srwce_pkg::PORT1_SEL) begin
                keep      = 1'b1;
                o_cmd.op  = srwce_pkg::OP_PUSH;
                o_cmd.sel = srwce_pkg::SEL_P1;
                o_cmd.b0  = i_addr[7:0];
                o_cmd.b1  = i_value;
            end
        end else if (i_chip == srwce_pkg::CHIP_PSG) begin
            if (i_addr == 32'd0) begin
                keep      = 1'b1;
                o_cmd.op  = srwce_pkg::OP_PUSH;
                o_cmd.sel = srwce_pkg::SEL_PSG;
                o_cmd.b0  = 8'h00;
                o_cmd.b1  = i_value;
            end
        end else if (i_chip == srwce_pkg::CHIP_DAC) begin
            keep = pcm_keep;
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;

endmodule
`default_nettype wire

@@ hdl/srwce_queue.sv @@
// Command queue between the front end and the back end.
// Depends on srwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srwce_queue #(
    parameter int DEPTH = srwce_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire srwce_pkg::t_cmd  i_cmd,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output srwce_pkg::t_cmd       o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    srwce_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ hdl/srwce_back.sv @@
// Back end: batch buffers, fill counts, drain sequencer and output register.
// Depends on srwce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srwce_back #(
    parameter int BATCH_LIMIT = srwce_pkg::BATCH_LIMIT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire srwce_pkg::t_cmd  i_cmd,
    output logic                  o_cmd_ready,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    output logic [7:0]            o_m_byte,
    output logic                  o_m_last
);

    localparam int FW = (BATCH_LIMIT > 1) ? $clog2(BATCH_LIMIT) : 1;
    localparam int CW = $clog2(BATCH_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT = CW'(BATCH_LIMIT);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PCM  = 5'b00010,
        ST_HDR  = 5'b00100,
        ST_HI   = 5'b01000,
        ST_LO   = 5'b10000
    } t_state;

    logic [15:0] r_mem0 [BATCH_LIMIT];
    logic [15:0] r_mem1 [BATCH_LIMIT];
    logic [7:0]  r_memp [BATCH_LIMIT];
    logic [15:0] r_rd0;
    logic [15:0] r_rd1;
    logic [7:0]  r_rdp;

    t_state          r_state, n_state;
    srwce_pkg::t_sel r_sel,   n_sel;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic [FW-1:0]   r_idx,   n_idx;
    logic            r_more,  n_more;
    logic [7:0]      r_pcm,   n_pcm;
    logic [FW-1:0]   r_fill0, n_fill0;
    logic [FW-1:0]   r_fill1, n_fill1;
    logic [FW-1:0]   r_fillp, n_fillp;
    logic            r_mvalid, n_mvalid;
    logic [7:0]      r_mbyte,  n_mbyte;
    logic            r_mlast,  n_mlast;

    logic            adv;
    logic            emit;
    logic [7:0]      e_byte;
    logic            e_last;
    logic            wr_en;
    logic [FW-1:0]   push_fill;
    logic            push_full;
    logic [CW-1:0]   cnt_m1;
    logic            at_end;
    logic [7:0]      rd_hi;
    logic [7:0]      rd_lo;

    assign adv    = !r_mvalid || i_m_ready;
    assign cnt_m1 = r_cnt - CW'(1);
    assign at_end = CW'(r_idx) == cnt_m1;

    always_comb begin
        case (r_sel)
            srwce_pkg::SEL_P0: begin
                rd_hi = r_rd0[15:8];
                rd_lo = r_rd0[7:0];
            end
            srwce_pkg::SEL_P1: begin
                rd_hi = r_rd1[15:8];
                rd_lo = r_rd1[7:0];
            end
            default: begin
                rd_hi = 8'h00;
                rd_lo = r_rdp;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            srwce_pkg::SEL_P0: push_fill = r_fill0;
            srwce_pkg::SEL_P1: push_fill = r_fill1;
            default:           push_fill = r_fillp;
        endcase
    end

    assign push_full = (CW'(push_fill) + CW'(1)) == LIMIT;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_more  = r_more;
        n_pcm   = r_pcm;
        n_fill0 = r_fill0;
        n_fill1 = r_fill1;
        n_fillp = r_fillp;
        emit    = 1'b0;
        e_byte  = 8'h00;
        e_last  = 1'b0;
        wr_en   = 1'b0;
        o_cmd_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = adv;
                if (i_cmd_valid && adv) begin
                    case (i_cmd.op)
                        srwce_pkg::OP_PCM: begin
                            emit    = 1'b1;
                            e_byte  = i_cmd.b0;
                            n_pcm   = i_cmd.b1;
                            n_state = ST_PCM;
                        end
                        srwce_pkg::OP_PUSH: begin
                            wr_en = 1'b1;
                            case (i_cmd.sel)
                                srwce_pkg::SEL_P0: n_fill0 = push_full ? '0 : r_fill0 + FW'(1);
                                srwce_pkg::SEL_P1: n_fill1 = push_full ? '0 : r_fill1 + FW'(1);
                                default:           n_fillp = push_full ? '0 : r_fillp + FW'(1);
                            endcase
                            if (push_full) begin
                                n_sel   = i_cmd.sel;
                                n_cnt   = LIMIT;
                                n_more  = 1'b0;
                                n_state = ST_HDR;
                            end
                        end
                        srwce_pkg::OP_FLUSH_FM: begin
                            if (r_fill0 != '0) begin
                                n_sel   = srwce_pkg::SEL_P0;
                                n_cnt   = CW'(r_fill0);
                                n_more  = r_fill1 != '0;
                                n_fill0 = '0;
                                n_state = ST_HDR;
                            end else if (r_fill1 != '0) begin
                                n_sel   = srwce_pkg::SEL_P1;
                                n_cnt   = CW'(r_fill1);
                                n_more  = 1'b0;
                                n_fill1 = '0;
                                n_state = ST_HDR;
                            end
                        end
                        default: begin
                            if (r_fillp != '0) begin
                                n_sel   = srwce_pkg::SEL_PSG;
                                n_cnt   = CW'(r_fillp);
                                n_more  = 1'b0;
                                n_fillp = '0;
                                n_state = ST_HDR;
                            end
                        end
                    endcase
                end
            end
            ST_PCM: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_byte  = r_pcm;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_byte  = srwce_pkg::hdr_base(r_sel) | (8'(cnt_m1) & 8'h0F);
                    n_idx   = '0;
                    n_state = (r_sel == srwce_pkg::SEL_PSG) ? ST_LO : ST_HI;
                end
            end
            ST_HI: begin
                if (adv) begin
                    emit    = 1'b1;
                    e_byte  = rd_hi;
                    n_state = ST_LO;
                end
            end
            ST_LO: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_byte = rd_lo;
                    e_last = at_end && !r_more;
                    if (at_end) begin
                        if (r_more) begin
                            n_sel   = srwce_pkg::SEL_P1;
                            n_cnt   = CW'(r_fill1);
                            n_fill1 = '0;
                            n_more  = 1'b0;
                            n_state = ST_HDR;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + FW'(1);
                        n_state = (r_sel == srwce_pkg::SEL_PSG) ? ST_LO : ST_HI;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_mvalid = emit || (r_mvalid && !i_m_ready);
        n_mbyte  = emit ? e_byte : r_mbyte;
        n_mlast  = emit ? e_last : r_mlast;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (i_cmd.sel)
                srwce_pkg::SEL_P0: r_mem0[push_fill] <= {i_cmd.b0, i_cmd.b1};
                srwce_pkg::SEL_P1: r_mem1[push_fill] <= {i_cmd.b0, i_cmd.b1};
                default:           r_memp[push_fill] <= i_cmd.b1;
            endcase
        end
        r_rd0 <= r_mem0[n_idx];
        r_rd1 <= r_mem1[n_idx];
        r_rdp <= r_memp[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_more  <= n_more;
        r_pcm   <= n_pcm;
        r_mbyte <= n_mbyte;
        r_mlast <= n_mlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill0  <= '0;
            r_fill1  <= '0;
            r_fillp  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill0  <= n_fill0;
            r_fill1  <= n_fill1;
            r_fillp  <= n_fillp;
            r_mvalid <= n_mvalid;
        end
    end

    assign o_m_valid = r_mvalid;
    assign o_m_byte  = r_mbyte;
    assign o_m_last  = r_mlast;

endmodule
`default_nettype wire

@@ hdl/sound_register_write_command_encoder.sv @@
// A PCM command's first byte is loaded into the output register when the back
// end accepts the command. The input takes one transaction per cycle while the
// QUEUE_DEPTH-entry queue has room. A batch drain emits a header byte, then a
// high and a low byte per FM entry or one low byte per PSG entry.
// Reset: synchronous, active low; clears fill counts, queue and output stage.
`timescale 1ns / 1ps
`default_nettype none
module sound_register_write_command_encoder #(
    parameter int BATCH_LIMIT = srwce_pkg::BATCH_LIMIT_DEF,
    parameter int QUEUE_DEPTH = srwce_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // write_address[31:0], write_value[39:32], sample_slot[45:40], pcm_base[47:46]
    input  wire logic [47:0] s_axis_tdata,
    // func[0], chip_kind[2:1]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);

    logic            q_ready;
    logic            push;
    srwce_pkg::t_cmd push_cmd;
    logic            q_valid;
    logic            q_pop;
    srwce_pkg::t_cmd q_cmd;

    srwce_front u_front (
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_func    (s_axis_tuser[0]),
        .i_chip    (s_axis_tuser[2:1]),
        .i_addr    (s_axis_tdata[31:0]),
        .i_value   (s_axis_tdata[39:32]),
        .i_slot    (s_axis_tdata[45:40]),
        .i_base    (s_axis_tdata[47:46]),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    srwce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    srwce_back #(
        .BATCH_LIMIT (BATCH_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_pop),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_byte    (m_axis_tdata),
        .o_m_last    (m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ hdl/srwce_checker.sv @@
// Port-level checker for the sound register write command encoder, bound to
// the top level. Depends on sound_register_write_command_encoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sound_register_write_command_encoder_assert.svh"
module srwce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic       in_seen;
    logic       out_stall;
    logic [9:0] out_word;
    logic       reset_state;

    assign in_seen     = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_word    = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};
    assign reset_state = s_axis_tready && !m_axis_tvalid;

    `SRWCE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_word))
    `SRWCE_ASSERT_IMP(a_reset_clear, i_clk, i_rst_n, !$past(i_rst_n), reset_state)
    `SRWCE_ASSERT_IMP(a_full_after_accept, i_clk, i_rst_n, $fell(s_axis_tready), $past(in_seen))

endmodule

bind sound_register_write_command_encoder srwce_checker u_srwce_checker (.*);
`default_nettype wire
